// ===== hdl/lsm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lsm_pkg;

	// Window depth and the longest usable pattern
	localparam int unsigned LSM_MAX_PAT = 16;
	localparam int unsigned LSM_LEN_W   = $clog2(LSM_MAX_PAT + 1);
	localparam int unsigned LSM_CHAR_W  = 8;
	localparam int unsigned LSM_LINE_W  = 32;
	localparam int unsigned LSM_CFG_W   = 64;
	localparam int unsigned LSM_CFG_IDX_W = 2;
	localparam int unsigned LSM_PAT_BYTES = 16;
	localparam int unsigned LSM_PLEN_W  = 5;

	// Special bytes
	localparam logic [LSM_CHAR_W-1:0] LSM_NL  = 8'd10;
	localparam logic [LSM_CHAR_W-1:0] LSM_NUL = 8'd0;

	// Configuration register indexes
	localparam logic [LSM_CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd0;
	localparam logic [LSM_CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd1;
	localparam logic [LSM_CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd2;
	localparam logic [LSM_CFG_IDX_W-1:0] CFG_FIRST    = 2'd3;

	// One byte handed from the input stage to the window
	typedef struct packed {
		logic                  go;
		logic [LSM_CHAR_W-1:0] chr;
	} lsm_step_t;

	// Map A-Z onto a-z, leave everything else alone
	function automatic logic [LSM_CHAR_W-1:0] lsm_fold(input logic [LSM_CHAR_W-1:0] c);
		logic [LSM_CHAR_W-1:0] r;
		r = c;
		if (c >= 8'd65 && c <= 8'd90)
			r = c + 8'd32;
		return r;
	endfunction

	// Clamp the configured length to the window depth
	function automatic logic [LSM_LEN_W-1:0] lsm_used_len(input logic [LSM_PLEN_W-1:0] len);
		logic [LSM_LEN_W-1:0] r;
		if (32'(len) > LSM_MAX_PAT)
			r = LSM_LEN_W'(LSM_MAX_PAT);
		else
			r = LSM_LEN_W'(len);
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/lsm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Text byte channel
interface lsm_char_if import lsm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [LSM_CHAR_W-1:0] char_in;

	modport source (output valid, output char_in, input ready);
	modport sink   (input valid, input char_in, output ready);
endinterface

// Matched line number channel
interface lsm_line_if import lsm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [LSM_LINE_W-1:0] matched_line;

	modport source (output valid, output matched_line, input ready);
	modport sink   (input valid, input matched_line, output ready);
endinterface

`default_nettype wire

// ===== hdl/lsm_window.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lsm_window import lsm_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire lsm_step_t                 step,
	input  wire logic [8*LSM_PAT_BYTES-1:0] pattern,
	input  wire logic [LSM_LEN_W-1:0]      used_len,
	output logic                           found
);

	logic [LSM_CHAR_W-1:0] win_q [LSM_MAX_PAT];
	logic [LSM_CHAR_W-1:0] win_nx [LSM_MAX_PAT];
	logic [LSM_CHAR_W-1:0] pat_f [LSM_MAX_PAT];
	logic [LSM_LEN_W-1:0]  fill_q;
	logic [LSM_LEN_W-1:0]  fill_nx;
	logic                  found_q;
	logic                  nul_q;
	logic [LSM_MAX_PAT:0]  len_hit;
	logic                  hit;
	logic                  is_nl;
	logic                  is_nul;

	assign found  = found_q;
	assign is_nl  = (step.chr == LSM_NL);
	assign is_nul = (step.chr == LSM_NUL);

	// Shifted window with the new folded byte in entry 0
	always_comb begin
		win_nx[0] = lsm_fold(step.chr);
		for (int j = 1; j < LSM_MAX_PAT; j++)
			win_nx[j] = win_q[j-1];
		for (int i = 0; i < LSM_MAX_PAT; i++)
			pat_f[i] = lsm_fold(pattern[8*i +: 8]);
	end

	// Saturating fill count
	assign fill_nx = (fill_q == LSM_LEN_W'(LSM_MAX_PAT)) ? fill_q : fill_q + 1'b1;

	// Compare the newest L bytes against the pattern for every length L
	always_comb begin
		len_hit = '0;
		for (int l = 1; l <= LSM_MAX_PAT; l++) begin
			len_hit[l] = 1'b1;
			for (int i = 0; i < l; i++) begin
				if (win_nx[l-1-i] != pat_f[i])
					len_hit[l] = 1'b0;
			end
		end
	end

	assign hit = (used_len != '0) && (fill_nx >= used_len) && len_hit[used_len];

	// Shift the window on every accepted text byte that is not a newline and comes before any NUL in its line
	always_ff @(posedge clk) begin
		if (step.go && !is_nl && !nul_q && !is_nul)
			win_q <= win_nx;
	end

	// Line state: clear on newline, freeze after a NUL byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			found_q <= 1'b0;
			nul_q   <= 1'b0;
		end else if (step.go) begin
			priority if (is_nl) begin
				fill_q  <= '0;
				found_q <= 1'b0;
				nul_q   <= 1'b0;
			end else if (nul_q) begin
				fill_q <= fill_q;
			end else if (is_nul) begin
				nul_q <= 1'b1;
			end else begin
				fill_q <= fill_nx;
				if (hit)
					found_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/line_substring_matcher_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                 Beat
// char_ch   in   char_in [7:0]           one text byte
// line_ch   out  matched_line [31:0]     number of a line holding the pattern
// cfg_*     in   cfg_index, cfg_wdata    one register write per cycle of cfg_we
//
// One byte per cycle sustained while no held result stalls input; a newline's result is
// registered in the input register and then the result register around the window compare.
// Reset clears the line state, the line counter and both valid flags; no clearing pass.
// A held result stalls input only when the next buffered byte is a newline that emits.

module line_substring_matcher_core import lsm_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [LSM_CFG_IDX_W-1:0] cfg_index,
	input  wire logic [LSM_CFG_W-1:0]     cfg_wdata,
	lsm_char_if.sink                      char_ch,
	lsm_line_if.source                    line_ch
);

	logic [LSM_CFG_W-1:0]  pat_low_q;
	logic [LSM_CFG_W-1:0]  pat_high_q;
	logic [LSM_PLEN_W-1:0] pat_len_q;
	logic [LSM_LINE_W-1:0] line_q;
	logic                  v_s1;
	logic [LSM_CHAR_W-1:0] chr_s1;
	logic                  out_v_q;
	logic [LSM_LINE_W-1:0] out_line_q;
	logic [LSM_LEN_W-1:0]  used_len;
	logic                  found;
	logic                  nl_s1;
	logic                  emit;
	logic                  adv;
	logic                  in_rdy;
	lsm_step_t             step;

	assign used_len = lsm_used_len(pat_len_q);
	assign nl_s1    = (chr_s1 == LSM_NL);
	assign emit     = v_s1 && nl_s1 && (found || used_len == '0);
	assign adv      = v_s1 && (!emit || !out_v_q || line_ch.ready);
	assign in_rdy   = !v_s1 || adv;

	assign char_ch.ready        = in_rdy;
	assign line_ch.valid        = out_v_q;
	assign line_ch.matched_line = out_line_q;

	assign step.go  = adv;
	assign step.chr = chr_s1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			pat_len_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PAT_LOW:  pat_low_q  <= cfg_wdata;
				CFG_PAT_HIGH: pat_high_q <= cfg_wdata;
				CFG_PAT_LEN:  pat_len_q  <= cfg_wdata[LSM_PLEN_W-1:0];
				CFG_FIRST:    pat_len_q  <= pat_len_q;
				default:      pat_len_q  <= pat_len_q;
			endcase
		end
	end

	// Line counter: load on a CFG_FIRST write, advance on every processed newline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			line_q <= '0;
		else if (cfg_we && cfg_index == CFG_FIRST)
			line_q <= cfg_wdata[LSM_LINE_W-1:0];
		else if (adv && nl_s1)
			line_q <= line_q + 1'b1;
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (in_rdy)
			v_s1 <= char_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (in_rdy && char_ch.valid)
			chr_s1 <= char_ch.char_in;
	end

	// Result register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (adv && emit)
			out_v_q <= 1'b1;
		else if (line_ch.ready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv && emit)
			out_line_q <= line_q;
	end

	lsm_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.pattern  ({pat_high_q, pat_low_q}),
		.used_len (used_len),
		.found    (found)
	);

endmodule

`default_nettype wire

// ===== hdl/lsm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lsm_checker import lsm_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  char_valid,
	input wire logic                  char_ready,
	input wire logic                  line_valid,
	input wire logic                  line_ready,
	input wire logic [LSM_LINE_W-1:0] matched_line
);

	// Input stalls only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!char_ready |-> (line_valid && !line_ready))
		else $error("input stalled without a held result");

	// Leave reset with the result register empty
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !line_valid)
		else $error("result valid out of reset");

	// Hold a result until it is taken
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(line_valid && !line_ready) |=> line_valid)
		else $error("result dropped before taken");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(line_valid && !line_ready) |=> $stable(matched_line))
		else $error("result changed while stalled");

endmodule

bind line_substring_matcher_core lsm_checker u_lsm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.char_valid   (char_ch.valid),
	.char_ready   (char_ch.ready),
	.line_valid   (line_ch.valid),
	.line_ready   (line_ch.ready),
	.matched_line (line_ch.matched_line)
);

`default_nettype wire
